>>> sv/hsp_pkg.sv
// Package with sizes, codes and types shared by the substring search block.
package hsp_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int MAX_TEXT    = 1024;
  localparam int ALPHABET    = 256;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 10;
  localparam int PCNT_W = $clog2(MAX_PATTERN + 1);
  localparam int PIDX_W = $clog2(MAX_PATTERN);
  localparam int TCNT_W = $clog2(MAX_TEXT + 1);
  localparam int TIDX_W = $clog2(MAX_TEXT);
  localparam int SUM_W  = ((TCNT_W > PCNT_W) ? TCNT_W : PCNT_W) + 1;

  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_RD_LAST,
    S_LAST,
    S_TBL,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic              pat_ok;
    logic [PCNT_W-1:0] m;
    logic [TCNT_W-1:0] n;
  } scan_cmd_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } scan_res_t;

endpackage

>>> sv/hsp_in_if.sv
// Input channel interface: pattern and text bytes.
interface hsp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [hsp_pkg::BYTE_W-1:0] byte_value;
  logic                      last;

  modport source (output valid, output kind, output byte_value, output last, input ready);
  modport sink (input valid, input kind, input byte_value, input last, output ready);
endinterface

>>> sv/hsp_out_if.sv
// Result channel interface: found flag and match position.
interface hsp_out_if;
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [hsp_pkg::POS_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink (input valid, input found, input position, output ready);
endinterface

>>> sv/hsp_text_mem.sv
// Text byte memory with one write port and one registered read port.
module hsp_text_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [hsp_pkg::TIDX_W-1:0] wr_addr,
  input  logic [hsp_pkg::BYTE_W-1:0] wr_data,
  input  logic [hsp_pkg::TIDX_W-1:0] rd_addr,
  output logic [hsp_pkg::BYTE_W-1:0] rd_data
);
  import hsp_pkg::*;

  logic [BYTE_W-1:0] mem [MAX_TEXT];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

>>> sv/hsp_shift_tbl.sv
// Bad-character shift table: last-occurrence memory plus per-byte valid bits.
module hsp_shift_tbl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic                       wr_en,
  input  logic [hsp_pkg::BYTE_W-1:0] wr_addr,
  input  logic [hsp_pkg::PIDX_W-1:0] wr_idx,
  input  logic [hsp_pkg::BYTE_W-1:0] rd_addr,
  input  logic [hsp_pkg::PCNT_W-1:0] m,
  output logic [hsp_pkg::PCNT_W-1:0] shift
);
  import hsp_pkg::*;

  // Each entry holds the last pattern index (below m-1) where the byte occurs.
  logic [PIDX_W-1:0]   mem [ALPHABET];
  logic [ALPHABET-1:0] vld_r;
  logic [PIDX_W-1:0]   idx_rd_r;
  logic                hit_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_idx;
    end
    idx_rd_r <= mem[rd_addr];
    hit_rd_r <= vld_r[rd_addr];
  end

  // A byte absent from the pattern head shifts by the whole pattern length.
  assign shift = hit_rd_r ? (m - PCNT_W'(1) - PCNT_W'(idx_rd_r)) : m;
endmodule

>>> sv/hsp_seq.sv
// Search sequencer: one byte compare and one skip adder reused over every window.
module hsp_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hsp_pkg::scan_cmd_t         cmd,
  output logic                       idle,
  output logic [hsp_pkg::PIDX_W-1:0] pat_addr,
  input  logic [hsp_pkg::BYTE_W-1:0] pat_data,
  output logic [hsp_pkg::TIDX_W-1:0] txt_addr,
  input  logic [hsp_pkg::BYTE_W-1:0] txt_data,
  output logic [hsp_pkg::BYTE_W-1:0] tbl_addr,
  input  logic [hsp_pkg::PCNT_W-1:0] shift,
  output hsp_pkg::scan_res_t         res,
  output logic                       res_valid,
  input  logic                       res_take
);
  import hsp_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [TCNT_W-1:0] skip_r, skip_nxt;
  logic [PCNT_W-1:0] k_r, k_nxt;
  logic [PCNT_W-1:0] m_r, m_nxt;
  logic [TCNT_W-1:0] n_r, n_nxt;
  logic              found_r, found_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  logic [SUM_W-1:0]  addr_sum;
  logic [SUM_W-1:0]  skip_sum;
  logic [SUM_W-1:0]  end_sum;
  logic [PCNT_W-1:0] k_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    skip_r  <= skip_nxt;
    k_r     <= k_nxt;
    m_r     <= m_nxt;
    n_r     <= n_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
  end

  always_comb begin
    k_m1     = k_r - PCNT_W'(1);
    addr_sum = SUM_W'(skip_r) + SUM_W'((state_r == S_RD_LAST) ? m_r : k_r) - SUM_W'(1);
    skip_sum = SUM_W'(skip_r) + SUM_W'(shift);
    end_sum  = skip_sum + SUM_W'(m_r);

    pat_addr = k_m1[PIDX_W-1:0];
    txt_addr = addr_sum[TIDX_W-1:0];
    tbl_addr = txt_data;

    state_nxt = state_r;
    skip_nxt  = skip_r;
    k_nxt     = k_r;
    m_nxt     = m_r;
    n_nxt     = n_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;

    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          m_nxt     = cmd.m;
          n_nxt     = cmd.n;
          skip_nxt  = '0;
          k_nxt     = cmd.m;
          found_nxt = 1'b0;
          pos_nxt   = '0;
          if (!cmd.pat_ok || (cmd.m == '0) || (SUM_W'(cmd.m) > SUM_W'(cmd.n))) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (txt_data == pat_data) begin
          if (k_r == PCNT_W'(1)) begin
            found_nxt = 1'b1;
            pos_nxt   = POS_W'(skip_r);
            state_nxt = S_DONE;
          end else begin
            k_nxt     = k_m1;
            state_nxt = S_RD;
          end
        end else begin
          state_nxt = S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        state_nxt = S_LAST;
      end
      S_LAST: begin
        state_nxt = S_TBL;
      end
      S_TBL: begin
        skip_nxt = skip_sum[TCNT_W-1:0];
        if (end_sum > SUM_W'(n_r)) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = m_r;
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign idle         = (state_r == S_IDLE);
  assign res_valid    = (state_r == S_DONE);
  assign res.found    = found_r;
  assign res.position = pos_r;
endmodule

>>> sv/horspool_substring_search.sv
// Top level of the Boyer-Moore-Horspool substring search block.
//
//   Channel   Dir   Payload                       Item accepted when
//   in_ch     in    kind, byte_value, last        in_ch.valid && in_ch.ready
//   out_ch    out   found, position               out_ch.valid && out_ch.ready
//
// in_ch.ready is high only while no search runs; the shift table fills as the
// pattern streams in, so closing a pattern needs no table pass. After the last
// text byte the search runs on one shared byte comparator and skip adder over
// the text memory's single read port: a compared byte passes the read and check
// states, a window shift the last-byte read, last-byte and table states, and
// the done state presents the result. Reset is synchronous, active low, and
// clears counts, the pattern-held flag and all shift table valid bits at once.
// A result waiting in the output register does not hold up input bytes.
module horspool_substring_search (
  input logic      clk,
  input logic      rst_n,
  hsp_in_if.sink   in_ch,
  hsp_out_if.source out_ch
);
  import hsp_pkg::*;

  // Loader state: pattern bytes live in flip-flops, counts saturate.
  logic [BYTE_W-1:0] pat_store_r [MAX_PATTERN];
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic              pat_ready_r, pat_ready_nxt;
  logic [TCNT_W-1:0] tcnt_r, tcnt_nxt;

  logic              acc_in;
  logic              acc_pat;
  logic              acc_txt;
  logic [PCNT_W-1:0] pat_base;
  logic [PCNT_W-1:0] pat_prev;
  logic              pat_room;
  logic              pat_wr;
  logic              tbl_wr;
  logic              tbl_clr;
  logic              txt_room;
  logic              txt_wr;
  logic [TCNT_W-1:0] tcnt_inc;
  scan_cmd_t         cmd;

  // Sequencer links.
  logic              seq_idle;
  logic [PIDX_W-1:0] pat_addr;
  logic [BYTE_W-1:0] pat_data;
  logic [TIDX_W-1:0] txt_addr;
  logic [BYTE_W-1:0] txt_data;
  logic [BYTE_W-1:0] tbl_addr;
  logic [PCNT_W-1:0] shift;
  scan_res_t         res;
  logic              res_valid;
  logic              res_take;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r;
  logic [POS_W-1:0]  out_pos_r;

  // The block only takes bytes while no search is running.
  assign in_ch.ready = seq_idle;
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign acc_pat     = acc_in && (in_ch.kind == KIND_PATTERN);
  assign acc_txt     = acc_in && (in_ch.kind == KIND_TEXT);

  always_comb begin
    // A pattern byte after a closed pattern starts a fresh one at index zero.
    pat_base = pat_ready_r ? '0 : pcnt_r;
    pat_prev = pat_base - PCNT_W'(1);
    pat_room = (pat_base < PCNT_W'(MAX_PATTERN));
    pat_wr   = acc_pat && pat_room;
    // Storing byte i makes byte i-1 an interior pattern byte, so its table
    // entry is recorded now; the final byte never gets an entry.
    tbl_wr   = pat_wr && (pat_base != '0);
    tbl_clr  = acc_pat && pat_ready_r;

    pcnt_nxt      = pcnt_r;
    pat_ready_nxt = pat_ready_r;
    if (acc_pat) begin
      pcnt_nxt      = pat_room ? (pat_base + PCNT_W'(1)) : pat_base;
      pat_ready_nxt = in_ch.last;
    end

    txt_room = (tcnt_r < TCNT_W'(MAX_TEXT));
    txt_wr   = acc_txt && txt_room;
    tcnt_inc = txt_room ? (tcnt_r + TCNT_W'(1)) : tcnt_r;

    cmd.start  = acc_txt && in_ch.last;
    cmd.pat_ok = pat_ready_r;
    cmd.m      = pcnt_r;
    cmd.n      = tcnt_inc;

    tcnt_nxt = tcnt_r;
    if (acc_txt) begin
      // The text length travels with the start command, so the count can
      // return to zero at once.
      tcnt_nxt = in_ch.last ? '0 : tcnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r      <= '0;
      pat_ready_r <= 1'b0;
      tcnt_r      <= '0;
    end else begin
      pcnt_r      <= pcnt_nxt;
      pat_ready_r <= pat_ready_nxt;
      tcnt_r      <= tcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pat_wr) begin
      pat_store_r[pat_base[PIDX_W-1:0]] <= in_ch.byte_value;
    end
  end

  assign pat_data = pat_store_r[pat_addr];

  hsp_text_mem u_text_mem (
    .clk     (clk),
    .wr_en   (txt_wr),
    .wr_addr (tcnt_r[TIDX_W-1:0]),
    .wr_data (in_ch.byte_value),
    .rd_addr (txt_addr),
    .rd_data (txt_data)
  );

  hsp_shift_tbl u_shift_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (tbl_clr),
    .wr_en   (tbl_wr),
    .wr_addr (pat_store_r[pat_prev[PIDX_W-1:0]]),
    .wr_idx  (pat_prev[PIDX_W-1:0]),
    .rd_addr (tbl_addr),
    .m       (pcnt_r),
    .shift   (shift)
  );

  hsp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .idle      (seq_idle),
    .pat_addr  (pat_addr),
    .pat_data  (pat_data),
    .txt_addr  (txt_addr),
    .txt_data  (txt_data),
    .tbl_addr  (tbl_addr),
    .shift     (shift),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take)
  );

  // The result moves into the output register as soon as it is free or
  // being emptied in the same cycle.
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_found_r <= res.found;
      out_pos_r   <= res.position;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.position = out_pos_r;

  // The pattern count saturates at the pattern store depth.
  a_pcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PCNT_W'(MAX_PATTERN))
    else $error("pattern count beyond store depth");

  // The text count saturates at the text memory depth.
  a_tcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tcnt_r <= TCNT_W'(MAX_TEXT))
    else $error("text count beyond memory depth");

  // A search start leaves the text count cleared for the next text.
  a_tcnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (tcnt_r == '0))
    else $error("text count not cleared after search start");

  // A match can only be reported while a closed pattern is held.
  a_found_pat: assert property (@(posedge clk) disable iff (!rst_n)
    (res_take && res.found) |-> pat_ready_r)
    else $error("match reported without a closed pattern");

endmodule
